// ----- sv/mtfl_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtfl_pkg
// shared types and constants of the move-to-front id list unit
// ----------------------------------------------------------------------------
package mtfl_pkg;

	localparam int ID_W  = 32;
	localparam int CNT_W = 10;

	localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(999);

	// event kinds carried on the input side
	localparam logic [1:0] KIND_WIN   = 2'd0;
	localparam logic [1:0] KIND_LOSS  = 2'd1;
	localparam logic [1:0] KIND_TRADE = 2'd2;
	localparam logic [1:0] KIND_BAD   = 2'd3;

	// card type that lets the counters advance
	localparam logic [1:0] COUNTING_KIND = 2'd2;

	// register indexes on the config port
	localparam logic REG_RECORD = 1'b0;
	localparam logic REG_CARD   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} mtfl_state_t;

	// list update request from the sequencer to a list
	typedef struct packed {
		logic            en;
		logic [ID_W-1:0] id;
	} mtfl_upd_t;

endpackage
`default_nettype wire

// ----- sv/move_to_front_id_list_with_counters_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// move_to_front_id_list_with_counters_unit
// two move-to-front recency lists of partner ids with saturating counters
// ----------------------------------------------------------------------------
//
//  channel  | dir | beat contents
//  ---------+-----+-----------------------------------------------------------
//  s_*      | in  | tuser: event_kind; tdata: sender_id
//  m_*      | out | tdata: was_new, bad_event, win_total, loss_total, trade_total
//  apb      | in  | reg 0 recording_enabled (addr 0), reg 1 card_kind (addr 4)
//
//  an event passes from acceptance through the search walk and the update
//  step into the output register, and holds the sequencer for the whole beat:
//  one compare per cycle walks the selected list, the single 32-bit
//  comparator being the unit shared by every search step
//  an event that is not recorded (recording off or invalid kind) skips the walk
//  s_tready is high only while the sequencer is idle
//  the result sits in an output register; a stalled m_tready holds the
//  sequencer in its update step until the register drains
//  reset clears both lists to id 0 and all counters to zero
//
// ----------------------------------------------------------------------------
module move_to_front_id_list_with_counters_unit import mtfl_pkg::*; #(
	parameter int LIST_DEPTH = 5
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// event input
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] sender_id
	input  wire logic [1:0]  s_tuser,   // [1:0] event_kind
	// result output
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // [0] was_new, [1] bad_event, [11:2] win_total,
	                                    // [21:12] loss_total, [31:22] trade_total
	// config port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LIST_DEPTH - 1);

	// ------------------------------------------------------------------
	// config registers
	// ------------------------------------------------------------------
	logic       record_q;
	logic [1:0] card_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// byte offset within a word is ignored, bit 2 selects the register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_q <= 1'b0;
			card_q   <= 2'd0;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_RECORD: record_q <= pwdata[0];
				REG_CARD:   card_q   <= pwdata[1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RECORD: prdata = {31'd0, record_q};
			REG_CARD:   prdata = {30'd0, card_q};
			default:    prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// event registers and sequencer state
	// ------------------------------------------------------------------
	mtfl_state_t      state_q, state_nxt;
	logic [1:0]       kind_q;
	logic [ID_W-1:0]  id_q;
	logic             act_q;     // event is recorded into a list
	logic             bad_q;     // recording on but invalid kind
	logic [IDX_W-1:0] idx_q;     // search position
	logic [IDX_W-1:0] pos_q;     // hit position, or last entry on a miss
	logic             miss_q;

	logic             s_acc;
	logic             m_free;
	logic             in_act;
	logic             hit;
	logic             scan_end;
	logic             upd_go;

	logic [ID_W-1:0]  battle_rd;
	logic [ID_W-1:0]  trade_rd;
	logic [ID_W-1:0]  sel_rd;
	mtfl_upd_t        battle_upd;
	mtfl_upd_t        trade_upd;

	logic [CNT_W-1:0] win_q, loss_q, trade_q;
	logic [CNT_W-1:0] win_nxt, loss_nxt, trade_nxt;
	logic             bump;

	logic             m_tvalid_q;
	logic [31:0]      m_tdata_q;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		sat_inc = (c < COUNT_MAX) ? c + CNT_W'(1) : COUNT_MAX;
	endfunction

	assign s_acc    = s_tvalid && s_tready;
	assign m_free   = !m_tvalid_q || m_tready;
	assign in_act   = record_q && (s_tuser != KIND_BAD);

	// the one shared comparator: selected list entry against the event id
	assign sel_rd   = (kind_q == KIND_TRADE) ? trade_rd : battle_rd;
	assign hit      = (sel_rd == id_q);
	assign scan_end = hit || (idx_q == LAST_IDX);
	assign upd_go   = (state_q == ST_UPDATE) && m_free;

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_acc) begin
					state_nxt = in_act ? ST_SCAN : ST_UPDATE;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				if (m_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_SCAN:   s_tready = 1'b0;
			ST_UPDATE: s_tready = 1'b0;
			default:   s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// event capture and search walk
	always_ff @(posedge clk) begin
		if (s_acc) begin
			kind_q <= s_tuser;
			id_q   <= s_tdata;
			act_q  <= in_act;
			bad_q  <= record_q && (s_tuser == KIND_BAD);
			idx_q  <= '0;
			miss_q <= 1'b0;
			pos_q  <= '0;
		end else if (state_q == ST_SCAN) begin
			pos_q  <= idx_q;
			miss_q <= !hit;
			if (!scan_end) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------
	// lists
	// ------------------------------------------------------------------
	assign battle_upd.en = upd_go && act_q && (kind_q != KIND_TRADE);
	assign battle_upd.id = id_q;
	assign trade_upd.en  = upd_go && act_q && (kind_q == KIND_TRADE);
	assign trade_upd.id  = id_q;

	mtfl_list #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_battle (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (idx_q),
		.rd_data (battle_rd),
		.upd     (battle_upd),
		.upd_pos (pos_q)
	);

	mtfl_list #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_trade (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (idx_q),
		.rd_data (trade_rd),
		.upd     (trade_upd),
		.upd_pos (pos_q)
	);

	// ------------------------------------------------------------------
	// counters: new partner with the counting card type
	// ------------------------------------------------------------------
	assign bump = act_q && miss_q && (card_q == COUNTING_KIND);

	always_comb begin
		win_nxt   = win_q;
		loss_nxt  = loss_q;
		trade_nxt = trade_q;
		if (bump) begin
			unique case (kind_q)
				KIND_WIN:   win_nxt   = sat_inc(win_q);
				KIND_LOSS:  loss_nxt  = sat_inc(loss_q);
				KIND_TRADE: trade_nxt = sat_inc(trade_q);
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= '0;
			loss_q  <= '0;
			trade_q <= '0;
		end else if (upd_go) begin
			win_q   <= win_nxt;
			loss_q  <= loss_nxt;
			trade_q <= trade_nxt;
		end
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (upd_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			m_tdata_q <= {trade_nxt, loss_nxt, win_nxt, bad_q, act_q && miss_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(win_q <= COUNT_MAX) && (loss_q <= COUNT_MAX) && (trade_q <= COUNT_MAX))
		else $error("counter above saturation limit");

	a_cnt_only_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_UPDATE) |=> ($stable(win_q) && $stable(loss_q) && $stable(trade_q)))
		else $error("counter changed outside update step");

	a_new_bad_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(m_tdata_q[0] && m_tdata_q[1]))
		else $error("result flagged both new and bad");

	a_scan_recorded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (act_q && (idx_q <= LAST_IDX)))
		else $error("search walk on unrecorded event or past list end");

	a_upd_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !m_tready && (state_q == ST_UPDATE)) |=> (state_q == ST_UPDATE))
		else $error("update left while output register still full");

endmodule
`default_nettype wire

// ----- sv/mtfl_list.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// mtfl_list
// recency list of ids with one indexed read and a move-to-front update
// ----------------------------------------------------------------------------
module mtfl_list import mtfl_pkg::*; #(
	parameter int LIST_DEPTH = 5,
	localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] rd_idx,
	output logic      [ID_W-1:0]  rd_data,
	input  wire mtfl_upd_t        upd,
	input  wire logic [IDX_W-1:0] upd_pos
);

	logic [ID_W-1:0] ids_q [LIST_DEPTH];

	assign rd_data = ids_q[rd_idx];

	// entries up to the hit position move back one place, the id goes in front
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LIST_DEPTH; k++) begin
				ids_q[k] <= '0;
			end
		end else if (upd.en) begin
			ids_q[0] <= upd.id;
			for (int k = 1; k < LIST_DEPTH; k++) begin
				if (IDX_W'(k) <= upd_pos) begin
					ids_q[k] <= ids_q[k-1];
				end
			end
		end
	end

endmodule
`default_nettype wire
